// ===== rtl/cvh_pkg.sv =====
`timescale 1ns / 1ps
package cvh_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 16;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_SORT_RK,
    ST_SORT_KW,
    ST_SORT_RJ,
    ST_SORT_CMP,
    ST_DD_RD,
    ST_DD_CHK,
    ST_H_RD,
    ST_H_PT,
    ST_H_TST,
    ST_H_M1,
    ST_H_M2,
    ST_H_CMP,
    ST_H_RT2,
    ST_H_T2W,
    ST_H_PUSH,
    ST_E_RD,
    ST_E_LD,
    ST_E_WAIT
  } cvh_state_t;

  typedef enum logic [1:0] {
    TURN_IDLE,
    TURN_MUL1,
    TURN_MUL2
  } cvh_turn_cmd_t;

endpackage

// ===== rtl/cvh_if.sv =====
`timescale 1ns / 1ps
interface cvh_in_if #(parameter int COORD_BITS = cvh_pkg::COORD_BITS_DEF);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         set_end;

  modport source (output valid, point_x, point_y, set_end, input ready);
  modport sink (input valid, point_x, point_y, set_end, output ready);
endinterface

interface cvh_out_if #(parameter int COORD_BITS = cvh_pkg::COORD_BITS_DEF);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic                         vertex_last;
  logic                         overflow;

  modport source (output valid, vertex_x, vertex_y, vertex_last, overflow, input ready);
  modport sink (input valid, vertex_x, vertex_y, vertex_last, overflow, output ready);
endinterface

// ===== rtl/cvh_turn.sv =====
`timescale 1ns / 1ps
module cvh_turn #(
  parameter int COORD_BITS = cvh_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  cvh_pkg::cvh_turn_cmd_t       cmd,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  input  logic signed [COORD_BITS-1:0] t1x,
  input  logic signed [COORD_BITS-1:0] t1y,
  input  logic signed [COORD_BITS-1:0] t2x,
  input  logic signed [COORD_BITS-1:0] t2y,
  output logic                         not_ccw
);
  import cvh_pkg::*;

  localparam int DB = COORD_BITS + 1;
  localparam int PB = 2 * DB;

  logic signed [DB-1:0] op_a;
  logic signed [DB-1:0] op_b;
  logic signed [PB-1:0] prod;
  logic signed [PB-1:0] prod1_r;
  logic signed [PB-1:0] prod2_r;

  always_comb begin
    if (cmd == TURN_MUL1) begin
      op_a = DB'(t1x) - DB'(t2x);
      op_b = DB'(py) - DB'(t2y);
    end else begin
      op_a = DB'(px) - DB'(t2x);
      op_b = DB'(t1y) - DB'(t2y);
    end
    prod = PB'(op_a) * PB'(op_b);
  end

  always_ff @(posedge clk) begin
    if (cmd == TURN_MUL1) begin
      prod1_r <= prod;
    end
    if (cmd == TURN_MUL2) begin
      prod2_r <= prod;
    end
  end

  assign not_ccw = (prod1_r <= prod2_r);
endmodule

// ===== rtl/convex_hull_monotone_chain.sv =====
`timescale 1ns / 1ps
// Convex hull of a set of integer points by the monotone chain method.
// Points enter on the in_pt channel, one word per point; the word with
// set_end high closes the set. Up to MAX_POINTS points are stored; later
// points are dropped and every vertex of that set reports overflow.
// After the closing word the block sorts the points by x then y with an
// insertion sort over the point memory, removes duplicates, and builds the
// lower and upper chains. Turn tests run on one shared multiplier; a pop
// reloads from the stack when another test follows. Vertices then leave on
// out_vx, counter-clockwise from the leftmost point, each held until taken
// before the next is read. While sorting, building or emitting, in_pt.ready
// stays low; a stalled receiver simply holds the block in the emit phase
// with the current word stable. Loading takes one cycle per point.
// Synchronous reset returns the block to the loading phase with an empty
// store; no memory clearing pass is needed.
module convex_hull_monotone_chain #(
  parameter int MAX_POINTS = cvh_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = cvh_pkg::COORD_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  cvh_in_if.sink    in_pt,
  cvh_out_if.source out_vx
);
  import cvh_pkg::*;

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int SD = MAX_POINTS + 1;
  localparam int SW = $clog2(SD);
  localparam int DW = $clog2(SD + 1);
  localparam int EW = 2 * COORD_BITS;

  cvh_state_t state_r, state_nxt;
  cvh_turn_cmd_t turn_cmd;

  logic [EW-1:0] store_mem [MAX_POINTS];
  logic [EW-1:0] stack_mem [SD];
  logic [EW-1:0] rdata_r;
  logic [EW-1:0] srdata_r;
  logic [IW-1:0] raddr;
  logic [SW-1:0] sraddr;

  logic [CW-1:0] cnt_r, i_r, j_r, u_r, pi_r;
  logic [DW-1:0] d_r, base_r, k_r;
  logic          dropped_r, upper_r;
  logic [EW-1:0] key_r, prev_r, p_r, t1_r, t2_r;
  logic          not_ccw;
  logic          key_less, need_test;

  logic signed [COORD_BITS-1:0] kx, ky, rx, ry;

  assign kx = key_r[EW-1:COORD_BITS];
  assign ky = key_r[COORD_BITS-1:0];
  assign rx = rdata_r[EW-1:COORD_BITS];
  assign ry = rdata_r[COORD_BITS-1:0];
  assign key_less = (kx < rx) || ((kx == rx) && (ky < ry));
  assign need_test = (d_r >= base_r + DW'(2));

  cvh_turn #(.COORD_BITS(COORD_BITS)) u_turn (
    .clk    (clk),
    .cmd    (turn_cmd),
    .px     (p_r[EW-1:COORD_BITS]),
    .py     (p_r[COORD_BITS-1:0]),
    .t1x    (t1_r[EW-1:COORD_BITS]),
    .t1y    (t1_r[COORD_BITS-1:0]),
    .t2x    (t2_r[EW-1:COORD_BITS]),
    .t2y    (t2_r[COORD_BITS-1:0]),
    .not_ccw(not_ccw)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_pt.valid && in_pt.set_end) begin
          state_nxt = (cnt_r == '0) ? ST_DD_RD : ST_SORT_RK;
        end
      end
      ST_SORT_RK:  state_nxt = ST_SORT_KW;
      ST_SORT_KW:  state_nxt = ST_SORT_RJ;
      ST_SORT_RJ:  state_nxt = (j_r == '0) ?
                     ((i_r + CW'(1) == cnt_r) ? ST_DD_RD : ST_SORT_RK) : ST_SORT_CMP;
      ST_SORT_CMP: state_nxt = key_less ? ST_SORT_RJ :
                     ((i_r + CW'(1) == cnt_r) ? ST_DD_RD : ST_SORT_RK);
      ST_DD_RD:    state_nxt = ST_DD_CHK;
      ST_DD_CHK:   state_nxt = (i_r + CW'(1) == cnt_r) ? ST_H_RD : ST_DD_RD;
      ST_H_RD:     state_nxt = ST_H_PT;
      ST_H_PT:     state_nxt = ST_H_TST;
      ST_H_TST:    state_nxt = need_test ? ST_H_M1 : ST_H_PUSH;
      ST_H_M1:     state_nxt = ST_H_M2;
      ST_H_M2:     state_nxt = ST_H_CMP;
      ST_H_CMP: begin
        if (!not_ccw) begin
          state_nxt = ST_H_PUSH;
        end else if (d_r - DW'(1) >= base_r + DW'(2)) begin
          state_nxt = ST_H_RT2;
        end else begin
          state_nxt = ST_H_TST;
        end
      end
      ST_H_RT2:    state_nxt = ST_H_T2W;
      ST_H_T2W:    state_nxt = ST_H_TST;
      ST_H_PUSH: begin
        if (!upper_r && pi_r + CW'(1) == u_r) begin
          state_nxt = (u_r < CW'(3)) ? ST_E_RD : ST_H_RD;
        end else if (upper_r && pi_r == '0) begin
          state_nxt = ST_E_RD;
        end else begin
          state_nxt = ST_H_RD;
        end
      end
      ST_E_RD:     state_nxt = ST_E_LD;
      ST_E_LD:     state_nxt = ST_E_WAIT;
      ST_E_WAIT: begin
        if (out_vx.ready) begin
          state_nxt = out_vx.vertex_last ? ST_LOAD : ST_E_RD;
        end
      end
      default:     state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    raddr    = '0;
    sraddr   = '0;
    turn_cmd = TURN_IDLE;
    unique case (state_r)
      ST_SORT_RK: raddr = i_r[IW-1:0];
      ST_SORT_RJ: raddr = IW'(j_r - CW'(1));
      ST_DD_RD:   raddr = i_r[IW-1:0];
      ST_H_RD:    raddr = pi_r[IW-1:0];
      ST_H_M1:    turn_cmd = TURN_MUL1;
      ST_H_M2:    turn_cmd = TURN_MUL2;
      ST_H_RT2:   sraddr = SW'(d_r - DW'(2));
      ST_E_RD:    sraddr = SW'(k_r);
      default:    raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    rdata_r  <= store_mem[raddr];
    srdata_r <= stack_mem[sraddr];
    if (state_r == ST_LOAD && in_pt.valid && cnt_r != CW'(MAX_POINTS)) begin
      store_mem[cnt_r[IW-1:0]] <= {in_pt.point_x, in_pt.point_y};
    end
    if (state_r == ST_SORT_RJ && j_r == '0) begin
      store_mem[j_r[IW-1:0]] <= key_r;
    end
    if (state_r == ST_SORT_CMP) begin
      store_mem[j_r[IW-1:0]] <= key_less ? rdata_r : key_r;
    end
    if (state_r == ST_DD_CHK && (u_r == '0 || rdata_r != prev_r)) begin
      store_mem[u_r[IW-1:0]] <= rdata_r;
    end
    if (state_r == ST_H_PUSH) begin
      stack_mem[SW'(d_r)] <= p_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      cnt_r     <= '0;
      dropped_r <= 1'b0;
      out_vx.valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_LOAD: begin
          if (in_pt.valid) begin
            if (cnt_r != CW'(MAX_POINTS)) begin
              cnt_r <= cnt_r + CW'(1);
            end else begin
              dropped_r <= 1'b1;
            end
            i_r <= CW'(1);
            if (in_pt.set_end && cnt_r == '0) begin
              i_r <= '0;
            end
            u_r <= '0;
          end
        end
        ST_SORT_KW: begin
          key_r <= rdata_r;
          j_r   <= i_r;
        end
        ST_SORT_RJ: begin
          if (j_r == '0) begin
            i_r <= (i_r + CW'(1) == cnt_r) ? '0 : i_r + CW'(1);
          end
        end
        ST_SORT_CMP: begin
          if (key_less) begin
            j_r <= j_r - CW'(1);
          end else begin
            i_r <= (i_r + CW'(1) == cnt_r) ? '0 : i_r + CW'(1);
          end
        end
        ST_DD_CHK: begin
          if (u_r == '0 || rdata_r != prev_r) begin
            prev_r <= rdata_r;
            u_r    <= u_r + CW'(1);
          end
          i_r <= i_r + CW'(1);
          if (i_r + CW'(1) == cnt_r) begin
            pi_r    <= '0;
            d_r     <= '0;
            upper_r <= 1'b0;
            base_r  <= (u_r == '0 || rdata_r != prev_r) ?
                       ((u_r + CW'(1) < CW'(3)) ? DW'(u_r + CW'(1)) : '0) :
                       ((u_r < CW'(3)) ? DW'(u_r) : '0);
          end
        end
        ST_H_PT:  p_r <= rdata_r;
        ST_H_CMP: begin
          if (not_ccw) begin
            d_r  <= d_r - DW'(1);
            t1_r <= t2_r;
          end
        end
        ST_H_T2W: t2_r <= srdata_r;
        ST_H_PUSH: begin
          t1_r <= p_r;
          t2_r <= t1_r;
          if (!upper_r && pi_r + CW'(1) == u_r) begin
            k_r <= '0;
            if (u_r < CW'(3)) begin
              d_r <= d_r + DW'(1);
            end else begin
              base_r  <= d_r;
              upper_r <= 1'b1;
            end
          end else if (upper_r && pi_r == '0) begin
            k_r <= '0;
          end else begin
            d_r  <= d_r + DW'(1);
            pi_r <= upper_r ? pi_r - CW'(1) : pi_r + CW'(1);
          end
        end
        ST_E_LD: begin
          out_vx.valid       <= 1'b1;
          out_vx.vertex_x    <= srdata_r[EW-1:COORD_BITS];
          out_vx.vertex_y    <= srdata_r[COORD_BITS-1:0];
          out_vx.vertex_last <= (k_r + DW'(1) == d_r);
          out_vx.overflow    <= dropped_r;
        end
        ST_E_WAIT: begin
          if (out_vx.ready) begin
            out_vx.valid <= 1'b0;
            k_r          <= k_r + DW'(1);
            if (out_vx.vertex_last) begin
              cnt_r     <= '0;
              dropped_r <= 1'b0;
            end
          end
        end
        default: begin
          cnt_r <= cnt_r;
        end
      endcase
    end
  end

  assign in_pt.ready = (state_r == ST_LOAD);
endmodule

// ===== rtl/cvh_checker.sv =====
`timescale 1ns / 1ps
module cvh_checker #(
  parameter int COORD_BITS = cvh_pkg::COORD_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  in_set_end,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COORD_BITS-1:0] out_x,
  input logic [COORD_BITS-1:0] out_y,
  input logic                  out_last
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
    && $stable(out_last))
    else $error("vertex word changed while stalled");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input open while a vertex is pending");

  a_busy_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_set_end |=> !in_ready)
    else $error("input open right after the closing point");

  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> in_ready && !out_valid)
    else $error("block not back to loading after the last vertex");
endmodule

bind convex_hull_monotone_chain cvh_checker #(.COORD_BITS(COORD_BITS)) u_cvh_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_pt.valid),
  .in_ready  (in_pt.ready),
  .in_set_end(in_pt.set_end),
  .out_valid (out_vx.valid),
  .out_ready (out_vx.ready),
  .out_x     (out_vx.vertex_x),
  .out_y     (out_vx.vertex_y),
  .out_last  (out_vx.vertex_last)
);
